FILE: sv/trvm_pkg.sv
// Shared constants, types and decode helpers for the tiny register machine.
package trvm_pkg;

  // Storage sizes (program store depth must be a power of two, 16 to 256)
  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int NUM_REGS  = 4;
  localparam int REG_WIDTH = 32;
  localparam int REG_IDX_W = 2;
  localparam int OUT_W     = 32;

  // Opcodes
  localparam logic [7:0] OP_LOAD = 8'h01;
  localparam logic [7:0] OP_ADD  = 8'h02;
  localparam logic [7:0] OP_SUB  = 8'h03;
  localparam logic [7:0] OP_MOV  = 8'h04;
  localparam logic [7:0] OP_JMP  = 8'h05;
  localparam logic [7:0] OP_JZ   = 8'h06;
  localparam logic [7:0] OP_HALT = 8'hFF;

  // Result status codes
  localparam logic [2:0] ST_EXEC    = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_BAD_OP  = 3'd2;
  localparam logic [2:0] ST_NOT_RUN = 3'd3;
  localparam logic [2:0] ST_WRITTEN = 3'd4;

  // Command codes of the input word
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EXEC  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_OPA,
    S_OPB,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_HALT,
    K_BAD,
    K_ONE,
    K_TWO
  } op_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       mem_wr;
    logic       fetch;
    logic       lat_op;
    logic       lat_a;
    logic       exec_jmp;
    logic       exec_b;
    logic       halt;
    logic       set_status;
    logic [2:0] status;
    logic       clr_step;
    logic       out_load;
  } trvm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic     run;
    op_kind_t kind_rd;
    op_kind_t kind_q;
  } trvm_stat_t;

  // Classify an opcode by how many operand bytes follow it
  function automatic op_kind_t op_kind(input logic [7:0] op);
    op_kind_t k;
    case (op)
      OP_LOAD, OP_ADD, OP_SUB, OP_MOV, OP_JZ: k = K_TWO;
      OP_JMP:                                  k = K_ONE;
      OP_HALT:                                 k = K_HALT;
      default:                                 k = K_BAD;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/trvm_dpath.sv
// Datapath: program store, register file, pc, run flag and result register.
module trvm_dpath import trvm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  trvm_cmd_t               cmd,
  output trvm_stat_t              stat,
  input  logic [7:0]              mem_address,
  input  logic [7:0]              mem_data,
  output logic [2:0]              status,
  output logic [7:0]              pc_now,
  output logic [7:0]              opcode_seen,
  output logic                    jump_taken,
  output logic signed [OUT_W-1:0] reg_zero,
  output logic signed [OUT_W-1:0] reg_one,
  output logic signed [OUT_W-1:0] reg_two,
  output logic signed [OUT_W-1:0] reg_three
);

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld;
  logic [7:0]           rd_data;
  logic                 rd_vld;
  logic [7:0]           rd_byte;

  logic [REG_WIDTH-1:0] rf [NUM_REGS];
  logic [7:0]           pc;
  logic                 run;
  logic [7:0]           op_q;
  logic [7:0]           a_q;
  logic                 jump_q;
  logic [2:0]           status_q;

  logic [REG_WIDTH-1:0] va;
  logic [REG_WIDTH-1:0] vb;
  logic [REG_WIDTH-1:0] wval;
  logic                 wen;
  logic                 jz_take;
  logic [REG_WIDTH-1:0] rout [4];

  // Program store: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[mem_address[MEM_AW-1:0]] <= mem_data;
    end
    if (cmd.fetch) begin
      rd_data <= mem[pc[MEM_AW-1:0]];
    end
  end

  // Written marks: an unwritten byte reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (cmd.mem_wr) begin
        mem_vld[mem_address[MEM_AW-1:0]] <= 1'b1;
      end
      if (cmd.fetch) begin
        rd_vld <= mem_vld[pc[MEM_AW-1:0]];
      end
    end
  end

  assign rd_byte = rd_vld ? rd_data : 8'h00;

  // Operand reads; the register index is the low two bits of the operand byte
  always_comb begin
    va = '0;
    vb = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (a_q[REG_IDX_W-1:0] == REG_IDX_W'(i)) va = rf[i];
      if (rd_byte[REG_IDX_W-1:0] == REG_IDX_W'(i)) vb = rf[i];
    end
  end

  // Execute the two-operand instruction with the second operand on the read port
  always_comb begin
    wen  = 1'b0;
    wval = '0;
    case (op_q)
      OP_LOAD: begin
        wen  = 1'b1;
        wval = REG_WIDTH'(rd_byte);
      end
      OP_ADD: begin
        wen  = 1'b1;
        wval = va + vb;
      end
      OP_SUB: begin
        wen  = 1'b1;
        wval = va - vb;
      end
      OP_MOV: begin
        wen  = 1'b1;
        wval = vb;
      end
      default: begin
        wen  = 1'b0;
        wval = '0;
      end
    endcase
  end

  assign jz_take = (op_q == OP_JZ) && (va == '0);

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) rf[i] <= '0;
    end else if (cmd.exec_b && wen) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (a_q[REG_IDX_W-1:0] == REG_IDX_W'(i)) rf[i] <= wval;
      end
    end
  end

  // Program counter and run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= 8'h00;
      run <= 1'b1;
    end else begin
      if (cmd.fetch) begin
        pc <= pc + 8'd1;
      end else if (cmd.exec_jmp || (cmd.exec_b && jz_take)) begin
        pc <= rd_byte;
      end
      if (cmd.halt) begin
        run <= 1'b0;
      end
    end
  end

  // Per-instruction step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q     <= 8'h00;
      a_q      <= 8'h00;
      jump_q   <= 1'b0;
      status_q <= ST_EXEC;
    end else begin
      if (cmd.clr_step) begin
        op_q   <= 8'h00;
        jump_q <= 1'b0;
      end else begin
        if (cmd.lat_op) op_q <= rd_byte;
        if (cmd.exec_jmp || (cmd.exec_b && jz_take)) jump_q <= 1'b1;
      end
      if (cmd.lat_a) a_q <= rd_byte;
      if (cmd.set_status) status_q <= cmd.status;
    end
  end

  // Register view for the result: a slot past the register count reads zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rout[i] = '0;
      for (int j = 0; j < NUM_REGS; j++) begin
        if (i == j) rout[i] = rf[j];
      end
    end
  end

  // Result word register: registers are sign-extended or cut to the output width
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= status_q;
      pc_now      <= pc;
      opcode_seen <= op_q;
      jump_taken  <= jump_q;
      reg_zero    <= OUT_W'(signed'(rout[0]));
      reg_one     <= OUT_W'(signed'(rout[1]));
      reg_two     <= OUT_W'(signed'(rout[2]));
      reg_three   <= OUT_W'(signed'(rout[3]));
    end
  end

  assign stat.run     = run;
  assign stat.kind_rd = op_kind(rd_byte);
  assign stat.kind_q  = op_kind(op_q);

  // Single-port store: never write and fetch in one cycle
  a_one_port: assert property (@(posedge clk) disable iff (rst) !(cmd.mem_wr && cmd.fetch))
    else $error("program store written and read in the same cycle");

  // Once stopped, only reset restarts the machine
  a_run_no_rise: assert property (@(posedge clk) disable iff (rst) !run |=> !run)
    else $error("run flag set without reset");

  // The pc moves only on a fetch or a jump
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
      !cmd.fetch && !cmd.exec_jmp && !cmd.exec_b |=> $stable(pc))
    else $error("pc changed without fetch or jump");

endmodule

FILE: sv/trvm_ctrl.sv
// Controller: sequences fetch and execute steps and the output handshake.
module trvm_ctrl import trvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  output logic       out_valid,
  input  logic       out_stall,
  input  trvm_stat_t stat,
  output trvm_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_EXEC && stat.run) state_next = S_OP;
          else                                 state_next = S_DONE;
        end
      end
      S_OP: begin
        if (stat.kind_rd == K_ONE || stat.kind_rd == K_TWO) state_next = S_OPA;
        else                                                 state_next = S_DONE;
      end
      S_OPA: begin
        if (stat.kind_q == K_TWO) state_next = S_OPB;
        else                      state_next = S_DONE;
      end
      S_OPB: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.clr_step   = 1'b1;
          cmd.set_status = 1'b1;
          if (command == CMD_WRITE) begin
            cmd.mem_wr = 1'b1;
            cmd.status = ST_WRITTEN;
          end else if (!stat.run) begin
            cmd.status = ST_NOT_RUN;
          end else begin
            cmd.fetch  = 1'b1;
            cmd.status = ST_EXEC;
          end
        end
      end
      S_OP: begin
        cmd.lat_op = 1'b1;
        if (stat.kind_rd == K_ONE || stat.kind_rd == K_TWO) begin
          cmd.fetch = 1'b1;
        end else begin
          cmd.halt       = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = (stat.kind_rd == K_HALT) ? ST_HALTED : ST_BAD_OP;
        end
      end
      S_OPA: begin
        cmd.lat_a = 1'b1;
        if (stat.kind_q == K_TWO) cmd.fetch    = 1'b1;
        else                      cmd.exec_jmp = 1'b1;
      end
      S_OPB: cmd.exec_b = 1'b1;
      S_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, drop when the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled word");

  // An execute while running always starts with the opcode step
  a_exec_start: assert property (@(posedge clk) disable iff (rst)
      accept && command == CMD_EXEC && stat.run |=> state == S_OP)
    else $error("execute did not start with opcode step");

  // No fetch or store write while a result waits for the output register
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
      state == S_DONE |-> !cmd.fetch && !cmd.mem_wr)
    else $error("store access while finishing an item");

endmodule

FILE: sv/tiny_register_vm_core.sv
// Top level of the tiny register machine: controller plus datapath.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_stall  | command, mem_address, mem_data
//  out     | out_valid/out_stall| status, pc_now, opcode_seen, jump_taken, reg_*
//
// Steps per item up to the result load: byte write or execute while stopped go
// to the done step; HALT or unknown opcode end after the opcode step, JMP after
// operand one, two-operand instructions after operand two. The single-port
// program store, read one byte per cycle with registered data, sets the steps.
// Reset (rst, synchronous) clears the pc, registers and store marks at once and
// sets the machine running. A stalled output holds the finished item; no new
// item is taken until its result has moved into the output register.
module tiny_register_vm_core import trvm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [7:0]              mem_address,
  input  logic [7:0]              mem_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [7:0]              pc_now,
  output logic [7:0]              opcode_seen,
  output logic                    jump_taken,
  output logic signed [OUT_W-1:0] reg_zero,
  output logic signed [OUT_W-1:0] reg_one,
  output logic signed [OUT_W-1:0] reg_two,
  output logic signed [OUT_W-1:0] reg_three
);

  trvm_cmd_t  cmd;
  trvm_stat_t stat;

  trvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  trvm_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mem_address (mem_address),
    .mem_data    (mem_data),
    .status      (status),
    .pc_now      (pc_now),
    .opcode_seen (opcode_seen),
    .jump_taken  (jump_taken),
    .reg_zero    (reg_zero),
    .reg_one     (reg_one),
    .reg_two     (reg_two),
    .reg_three   (reg_three)
  );

endmodule
